### hdl/complex_dot_product_dual_check_defines.svh
// Assertion macros shared by the complex dot product RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef COMPLEX_DOT_PRODUCT_DUAL_CHECK_DEFINES_SVH
`define COMPLEX_DOT_PRODUCT_DUAL_CHECK_DEFINES_SVH

// Property that must hold at every sampled edge
`define CDPDC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication
`define CDPDC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CDPDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/cdpdc_pkg.sv
// Shared types and constants of the complex dot product block.
// No dependencies.
package cdpdc_pkg;

  // Depth of the queue between front and back end
  localparam int unsigned MidDepth = 4;
  // Depth of the result queue
  localparam int unsigned OutDepth = 2;
  // Widest complex product term kept; wider sums saturate to this
  localparam int unsigned TermMaxWidth = 64;

  // Status of a queue
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### hdl/cdpdc_fifo.sv
// Small register queue with first-word fall-through read.
// Depends on cdpdc_pkg and complex_dot_product_dual_check_defines.svh.
`include "complex_dot_product_dual_check_defines.svh"
module cdpdc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [WIDTH-1:0]     data_i,
  input  logic                 pop_i,
  output logic [WIDTH-1:0]     data_o,
  output cdpdc_pkg::q_stat_t   stat_o
);
  import cdpdc_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  // Handshake qualification
  assign stat_o.full  = (cnt_q == CntW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Hold pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `CDPDC_ASSERT(a_cnt_bound, cnt_q <= CntW'(DEPTH), "queue count exceeds depth")
  `CDPDC_ASSERT_NEXT(a_cnt_up, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1,
    "push without pop did not grow count")
  `CDPDC_ASSERT_IMPL(a_ptr_gap, stat_o.empty, wr_ptr_q == rd_ptr_q,
    "empty queue with pointers apart")

endmodule

### hdl/cdpdc_front.sv
// Front end: accepts element pairs, multiplies, forms the complex product terms.
// Depends on cdpdc_pkg.
module cdpdc_front #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned TERM_WIDTH = 33
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic signed [DATA_WIDTH-1:0] x_real_i,
  input  logic signed [DATA_WIDTH-1:0] x_imag_i,
  input  logic signed [DATA_WIDTH-1:0] y_real_i,
  input  logic signed [DATA_WIDTH-1:0] y_imag_i,
  input  logic                         last_i,
  output logic                         q_push_o,
  input  cdpdc_pkg::q_stat_t           q_stat_i,
  output logic signed [TERM_WIDTH-1:0] term_re_o,
  output logic signed [TERM_WIDTH-1:0] term_im_o,
  output logic                         last_o
);
  import cdpdc_pkg::*;

  localparam int unsigned ProdW = 2 * DATA_WIDTH;
  localparam int unsigned RawW  = ProdW + 1;

  logic                    v1_q, v2_q, en1, en2;
  logic signed [ProdW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic                    last1_q, last2_q;
  logic signed [RawW-1:0]  raw_re, raw_im;
  logic signed [TERM_WIDTH-1:0] t_re_d, t_im_d, t_re_q, t_im_q;

  // Stage enables, back-pressured by the middle queue
  assign en2    = !v2_q || !q_stat_i.full;
  assign en1    = !v1_q || en2;
  assign full_o = !en1;

  // Combine products into exact real and imaginary terms
  assign raw_re = RawW'(p_rr_q) - RawW'(p_ii_q);
  assign raw_im = RawW'(p_ri_q) + RawW'(p_ir_q);

  // Clamp terms that exceed the widest kept term
  if (RawW > TERM_WIDTH) begin : g_clamp
    always_comb begin
      t_re_d = TERM_WIDTH'(raw_re);
      t_im_d = TERM_WIDTH'(raw_im);
      if (raw_re[RawW-1] != raw_re[RawW-2]) begin
        t_re_d = {raw_re[RawW-1], {(TERM_WIDTH-1){~raw_re[RawW-1]}}};
      end
      if (raw_im[RawW-1] != raw_im[RawW-2]) begin
        t_im_d = {raw_im[RawW-1], {(TERM_WIDTH-1){~raw_im[RawW-1]}}};
      end
    end
  end else begin : g_pass
    assign t_re_d = TERM_WIDTH'(raw_re);
    assign t_im_d = TERM_WIDTH'(raw_im);
  end

  // Valid bits of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= push_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  // Multiply stage and term stage payload
  always_ff @(posedge clk_i) begin
    if (en1) begin
      p_rr_q  <= ProdW'(x_real_i) * ProdW'(y_real_i);
      p_ii_q  <= ProdW'(x_imag_i) * ProdW'(y_imag_i);
      p_ri_q  <= ProdW'(x_real_i) * ProdW'(y_imag_i);
      p_ir_q  <= ProdW'(x_imag_i) * ProdW'(y_real_i);
      last1_q <= last_i;
    end
    if (en2) begin
      t_re_q  <= t_re_d;
      t_im_q  <= t_im_d;
      last2_q <= last1_q;
    end
  end

  assign q_push_o  = v2_q;
  assign term_re_o = t_re_q;
  assign term_im_o = t_im_q;
  assign last_o    = last2_q;

endmodule

### hdl/cdpdc_back.sv
// Back end: twin saturating accumulators, cross-check and result queue.
// Depends on cdpdc_pkg, cdpdc_fifo and complex_dot_product_dual_check_defines.svh.
`include "complex_dot_product_dual_check_defines.svh"
module cdpdc_back #(
  parameter int unsigned ACC_WIDTH  = 48,
  parameter int unsigned TERM_WIDTH = 33
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cdpdc_pkg::q_stat_t           q_stat_i,
  input  logic signed [TERM_WIDTH-1:0] term_re_i,
  input  logic signed [TERM_WIDTH-1:0] term_im_i,
  input  logic                         last_i,
  output logic                         q_pop_o,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic signed [ACC_WIDTH-1:0]  sum_real_o,
  output logic signed [ACC_WIDTH-1:0]  sum_imag_o,
  output logic                         mismatch_o
);
  import cdpdc_pkg::*;

  localparam int unsigned SumW = ((ACC_WIDTH > TERM_WIDTH) ? ACC_WIDTH : TERM_WIDTH) + 1;
  localparam int unsigned ResW = 2 * ACC_WIDTH + 1;

  // Add a term to an accumulator, saturating at the accumulator bounds
  function automatic logic signed [ACC_WIDTH-1:0] sat_add(
    input logic signed [ACC_WIDTH-1:0]  acc,
    input logic signed [TERM_WIDTH-1:0] term
  );
    logic signed [SumW-1:0] s;
    logic [SumW-ACC_WIDTH:0] top;
    s   = SumW'(acc) + SumW'(term);
    top = s[SumW-1:ACC_WIDTH-1];
    if (top != '0 && top != '1) begin
      sat_add = {s[SumW-1], {(ACC_WIDTH-1){~s[SumW-1]}}};
    end else begin
      sat_add = s[ACC_WIDTH-1:0];
    end
  endfunction

  logic signed [ACC_WIDTH-1:0] a1_re_q, a1_im_q, a2_re_q, a2_im_q;
  logic signed [ACC_WIDTH-1:0] a1_re_d, a1_im_d, a2_re_d, a2_im_d;
  logic signed [ACC_WIDTH-1:0] h1_re_q, h1_im_q, h2_re_q, h2_im_q;
  logic                        hold_q, hold_en, take, out_push, diff;
  logic [ResW-1:0]             res_d, res_q;
  q_stat_t                     out_stat;

  // Take a term unless a finishing term finds the hold stage busy
  assign hold_en  = !hold_q || !out_stat.full;
  assign take     = !q_stat_i.empty && (!last_i || hold_en);
  assign q_pop_o  = take;
  assign out_push = hold_q && !out_stat.full;

  // Accumulate both copies
  assign a1_re_d = sat_add(a1_re_q, term_re_i);
  assign a1_im_d = sat_add(a1_im_q, term_im_i);
  assign a2_re_d = sat_add(a2_re_q, term_re_i);
  assign a2_im_d = sat_add(a2_im_q, term_im_i);

  // Hold accumulators, clear them on the last term
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_re_q <= '0;
      a1_im_q <= '0;
      a2_re_q <= '0;
      a2_im_q <= '0;
      hold_q  <= 1'b0;
    end else begin
      if (take) begin
        if (last_i) begin
          a1_re_q <= '0;
          a1_im_q <= '0;
          a2_re_q <= '0;
          a2_im_q <= '0;
        end else begin
          a1_re_q <= a1_re_d;
          a1_im_q <= a1_im_d;
          a2_re_q <= a2_re_d;
          a2_im_q <= a2_im_d;
        end
      end
      if (hold_en) begin
        hold_q <= take && last_i;
      end
    end
  end

  // Capture final sums of both copies
  always_ff @(posedge clk_i) begin
    if (take && last_i) begin
      h1_re_q <= a1_re_d;
      h1_im_q <= a1_im_d;
      h2_re_q <= a2_re_d;
      h2_im_q <= a2_im_d;
    end
  end

  // Cross-check copies, force zero on disagreement
  assign diff  = (h1_re_q != h2_re_q) || (h1_im_q != h2_im_q);
  assign res_d = diff ? {1'b1, {(2*ACC_WIDTH){1'b0}}} : {1'b0, h1_im_q, h1_re_q};

  cdpdc_fifo #(
    .WIDTH (ResW),
    .DEPTH (OutDepth)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (res_d),
    .pop_i  (pop_i),
    .data_o (res_q),
    .stat_o (out_stat)
  );

  assign empty_o    = out_stat.empty;
  assign sum_real_o = res_q[ACC_WIDTH-1:0];
  assign sum_imag_o = res_q[2*ACC_WIDTH-1:ACC_WIDTH];
  assign mismatch_o = res_q[ResW-1];

  `CDPDC_ASSERT_NEXT(a_last_holds, take && last_i, hold_q,
    "finishing term did not load the hold stage")
  `CDPDC_ASSERT_NEXT(a_last_clears, take && last_i,
    a1_re_q == '0 && a1_im_q == '0 && a2_re_q == '0 && a2_im_q == '0,
    "accumulators not cleared after the last term")
  `CDPDC_ASSERT_IMPL(a_copies_track, !take,
    a1_re_q == a2_re_q && a1_im_q == a2_im_q,
    "accumulator copies diverged")

endmodule

### hdl/complex_dot_product_dual_check.sv
// Top level of the streaming complex dot product with redundant accumulators.
// Depends on cdpdc_pkg, cdpdc_front, cdpdc_fifo and cdpdc_back.
//
// Channel   Direction  Handshake       Payload
// item      in         push, full      x_real_i x_imag_i y_real_i y_imag_i last_i
// result    out        empty, pop      sum_real_o sum_imag_o mismatch_o
//
// One element pair is taken every cycle unless full is high; the front end's
// multiply and term stages each hold one item, then a four-entry queue feeds
// the accumulators. A result is captured in the hold stage as its last term
// is taken and is visible once it enters the two-entry result queue.
// Reset empties all queues and zeroes the accumulators; no clearing pass.
// A stalled result side fills the result queue, then the middle queue, then
// raises full; terms that do not end a vector keep draining meanwhile.
module complex_dot_product_dual_check #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned ACC_WIDTH  = 48
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic signed [DATA_WIDTH-1:0] x_real_i,
  input  logic signed [DATA_WIDTH-1:0] x_imag_i,
  input  logic signed [DATA_WIDTH-1:0] y_real_i,
  input  logic signed [DATA_WIDTH-1:0] y_imag_i,
  input  logic                         last_i,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [ACC_WIDTH-1:0]  sum_real_o,
  output logic signed [ACC_WIDTH-1:0]  sum_imag_o,
  output logic                         mismatch_o
);
  import cdpdc_pkg::*;

  localparam int unsigned RawW  = 2 * DATA_WIDTH + 1;
  localparam int unsigned TermW = (RawW > TermMaxWidth) ? TermMaxWidth : RawW;
  localparam int unsigned MidW  = 2 * TermW + 1;

  logic                    f_push, b_pop, f_last, m_last;
  logic signed [TermW-1:0] f_re, f_im, m_re, m_im;
  logic [MidW-1:0]         m_data;
  q_stat_t                 mid_stat;

  // Accept and multiply
  cdpdc_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .TERM_WIDTH (TermW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .x_real_i  (x_real_i),
    .x_imag_i  (x_imag_i),
    .y_real_i  (y_real_i),
    .y_imag_i  (y_imag_i),
    .last_i    (last_i),
    .q_push_o  (f_push),
    .q_stat_i  (mid_stat),
    .term_re_o (f_re),
    .term_im_o (f_im),
    .last_o    (f_last)
  );

  // Decouple front and back
  cdpdc_fifo #(
    .WIDTH (MidW),
    .DEPTH (MidDepth)
  ) u_mid_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_push),
    .data_i ({f_last, f_im, f_re}),
    .pop_i  (b_pop),
    .data_o (m_data),
    .stat_o (mid_stat)
  );

  assign m_re   = m_data[TermW-1:0];
  assign m_im   = m_data[2*TermW-1:TermW];
  assign m_last = m_data[MidW-1];

  // Accumulate, check and deliver
  cdpdc_back #(
    .ACC_WIDTH  (ACC_WIDTH),
    .TERM_WIDTH (TermW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (mid_stat),
    .term_re_i  (m_re),
    .term_im_i  (m_im),
    .last_i     (m_last),
    .q_pop_o    (b_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .sum_real_o (sum_real_o),
    .sum_imag_o (sum_imag_o),
    .mismatch_o (mismatch_o)
  );

endmodule
